// ----- hdl/mmbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared types and constants of the memory map bus decoder: region layout in
// the flat byte store, decode windows and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmbd_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_MOD,
        ST_DONE
    } state_t;

    localparam logic [31:0] OPEN_BUS = 32'h1A00_0002;

    localparam int DEF_ROM_BYTES   = 33554432;
    localparam int BOARD_RAM_BYTES = 262144;
    localparam int CHIP_RAM_BYTES  = 32768;
    localparam int VRAM_BYTES      = 98304;
    localparam int SRAM_BYTES      = 65536;
    localparam int BOOT_BYTES      = 16384;
    localparam int SMALL_BYTES     = 1024;

    // Byte offsets of each region inside the flat store. The regions that
    // reset to zero sit first, so one sweep from zero clears them all.
    localparam int BOARD_BASE = 32'h0000_0000;
    localparam int VRAM_BASE  = 32'h0004_0000;
    localparam int SRAM_BASE  = 32'h0005_8000;
    localparam int CHIP_BASE  = 32'h0006_8000;
    localparam int IO_BASE    = 32'h0007_0000;
    localparam int PAL_BASE   = 32'h0007_0400;
    localparam int OAM_BASE   = 32'h0007_0800;
    localparam int CLEAR_END  = 32'h0007_0C00;
    localparam int BOOT_BASE  = 32'h0007_0C00;
    localparam int ROM_BASE   = 32'h0008_0000;

    localparam logic [25:0] IO_LIMIT     = 26'h3FE;
    localparam logic [31:0] IO_VIDEO_END = 32'h0400_0056;
    localparam logic [31:0] TIMER_LO     = 32'h0400_0100;
    localparam logic [31:0] TIMER_HI     = 32'h0400_010F;
    localparam logic [25:0] IF_LO        = 26'h202;
    localparam logic [25:0] IF_HI        = 26'h203;

endpackage

`default_nettype wire

// ----- hdl/mmbd_ram.sv -----
// ----------------------------------------------------------------------------
// mmbd_ram
// Single-port byte-wide synchronous memory with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmbd_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/memory_map_bus_decoder_core.sv -----
// ----------------------------------------------------------------------------
// memory_map_bus_decoder_core
// System bus decoder of a handheld console memory map over one flat byte store.
// ----------------------------------------------------------------------------
// Usage: one item on the s_ channel is one read or write access of width
// s_width_code at s_address. Each item gives exactly one result item on the
// m_ channel: read data (little-endian, or the open-bus value for a rejected
// read, zero for writes), a video write flag and a timer access flag.
// All state lives in one single-port byte memory with a registered read, so
// bytes are handled one at a time. An item takes a decode step (ST_CHECK),
// then for each byte a read step (ST_READ) and a capture or read-modify-write
// step (ST_MOD), and m_valid rises in ST_DONE; a rejected access goes from
// ST_CHECK straight to ST_DONE. With m_ready high the result is taken and the
// block returns to ST_IDLE, where the next item can be accepted.
// One item is in flight at a time; s_ready is high only when no item is in
// work and no result is waiting.
// After reset the block sweeps the zero-reset regions of the store, one byte
// a cycle, before s_ready rises. A stalled m_ready holds the result and keeps
// s_ready low. Boot ROM and cartridge ROM contents are undefined until
// written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module memory_map_bus_decoder_core #(
    parameter int ROM_BYTES = mmbd_pkg::DEF_ROM_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [31:0] s_address,
    input  wire logic [1:0]  s_width_code,
    input  wire logic [31:0] s_write_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_read_data,
    output logic             m_video_write,
    output logic             m_timer_access
);

    localparam int MEM_DEPTH = mmbd_pkg::ROM_BASE + ROM_BYTES;
    localparam int AW        = $clog2(MEM_DEPTH);

    mmbd_pkg::state_t state_reg, state_next;

    logic          wr_reg;
    logic [31:0]   addr_reg;
    logic [1:0]    wc_reg;
    logic [31:0]   wdata_reg;
    logic [1:0]    cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg;
    logic [31:0]   rd_reg;
    logic          vid_reg, tmr_reg;

    // Decode of the captured request.
    logic [7:0]    top;
    logic [25:0]   off;
    logic [25:0]   size;
    logic [AW-1:0] base;
    logic          region_ok, wrap, is_io, video;
    logic [25:0]   nbytes;
    logic [1:0]    last_cnt;
    logic          ok;
    logic [25:0]   idx;
    logic [AW-1:0] flat;
    logic [7:0]    wbyte;
    logic          w1c;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    always_comb begin
        top       = addr_reg[31:24];
        off       = {2'b00, addr_reg[23:0]};
        size      = 26'(mmbd_pkg::SMALL_BYTES);
        base      = AW'(mmbd_pkg::IO_BASE);
        region_ok = 1'b1;
        wrap      = 1'b0;
        is_io     = 1'b0;
        video     = 1'b0;
        case (top)
            8'h00: begin
                base = AW'(mmbd_pkg::BOOT_BASE);
                size = 26'(mmbd_pkg::BOOT_BYTES);
            end
            8'h02: begin
                base = AW'(mmbd_pkg::BOARD_BASE);
                size = 26'(mmbd_pkg::BOARD_RAM_BYTES);
            end
            8'h03: begin
                base = AW'(mmbd_pkg::CHIP_BASE);
                off  = {11'd0, addr_reg[14:0]};
                size = 26'(mmbd_pkg::CHIP_RAM_BYTES);
                wrap = 1'b1;
            end
            8'h04: begin
                is_io = 1'b1;
                video = addr_reg < mmbd_pkg::IO_VIDEO_END;
            end
            8'h05: begin
                base  = AW'(mmbd_pkg::PAL_BASE);
                video = 1'b1;
            end
            8'h06: begin
                base  = AW'(mmbd_pkg::VRAM_BASE);
                size  = 26'(mmbd_pkg::VRAM_BYTES);
                video = 1'b1;
            end
            8'h07: begin
                base  = AW'(mmbd_pkg::OAM_BASE);
                video = 1'b1;
            end
            8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin
                // Only the 0x08 and 0x09 windows take writes.
                region_ok = !(wr_reg && top > 8'h09);
                base      = AW'(mmbd_pkg::ROM_BASE);
                off       = {1'b0, addr_reg[24:0]};
                size      = 26'(ROM_BYTES);
            end
            8'h0E: begin
                region_ok = (wc_reg == 2'd0);
                base      = AW'(mmbd_pkg::SRAM_BASE);
                size      = 26'(mmbd_pkg::SRAM_BYTES);
            end
            default: begin
                region_ok = 1'b0;
            end
        endcase

        case (wc_reg)
            2'd0:    begin nbytes = 26'd1; last_cnt = 2'd0; end
            2'd1:    begin nbytes = 26'd2; last_cnt = 2'd1; end
            default: begin nbytes = 26'd4; last_cnt = 2'd3; end
        endcase

        ok = (wc_reg != 2'd3) && region_ok
            && (wrap || (off + nbytes <= size))
            && (!is_io || off <= mmbd_pkg::IO_LIMIT);

        idx = off + 26'(cnt_reg);
        if (wrap) begin
            idx = idx & 26'(mmbd_pkg::CHIP_RAM_BYTES - 1);
        end
        flat  = base + AW'(idx);
        wbyte = wdata_reg[8*cnt_reg +: 8];
        // Interrupt-flag bytes clear where a one is written.
        w1c   = is_io && (idx == mmbd_pkg::IF_LO || idx == mmbd_pkg::IF_HI);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_addr   = flat;
        ram_wdata  = w1c ? (ram_rdata & ~wbyte) : wbyte;
        case (state_reg)
            mmbd_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 8'd0;
                if (clr_reg == AW'(mmbd_pkg::CLEAR_END - 1)) begin
                    state_next = mmbd_pkg::ST_IDLE;
                end
            end
            mmbd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = mmbd_pkg::ST_CHECK;
                end
            end
            mmbd_pkg::ST_CHECK: begin
                cnt_next   = 2'd0;
                state_next = ok ? mmbd_pkg::ST_READ : mmbd_pkg::ST_DONE;
            end
            mmbd_pkg::ST_READ: begin
                state_next = mmbd_pkg::ST_MOD;
            end
            mmbd_pkg::ST_MOD: begin
                ram_we = wr_reg;
                if (cnt_reg == last_cnt) begin
                    state_next = mmbd_pkg::ST_DONE;
                end else begin
                    cnt_next   = cnt_reg + 2'd1;
                    state_next = mmbd_pkg::ST_READ;
                end
            end
            mmbd_pkg::ST_DONE: begin
                if (m_ready) begin
                    state_next = mmbd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mmbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mmbd_pkg::ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == mmbd_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mmbd_pkg::ST_IDLE && s_valid) begin
            wr_reg    <= s_req_type;
            addr_reg  <= s_address;
            wc_reg    <= s_width_code;
            wdata_reg <= s_write_data;
        end
        if (state_reg == mmbd_pkg::ST_CHECK) begin
            rd_reg  <= (wr_reg || ok) ? 32'd0 : mmbd_pkg::OPEN_BUS;
            vid_reg <= ok && wr_reg && video;
            tmr_reg <= ok && addr_reg >= mmbd_pkg::TIMER_LO
                          && addr_reg <= mmbd_pkg::TIMER_HI;
        end
        if (state_reg == mmbd_pkg::ST_MOD && !wr_reg) begin
            rd_reg[8*cnt_reg +: 8] <= ram_rdata;
        end
    end

    mmbd_ram #(
        .DEPTH(MEM_DEPTH),
        .AW   (AW)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign s_ready        = (state_reg == mmbd_pkg::ST_IDLE);
    assign m_valid        = (state_reg == mmbd_pkg::ST_DONE);
    assign m_read_data    = rd_reg;
    assign m_video_write  = vid_reg;
    assign m_timer_access = tmr_reg;

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == mmbd_pkg::ST_CHECK))
        else $error("accepted item did not enter decode");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && wr_reg) |-> (m_read_data == 32'd0))
        else $error("write result carries read data");

    a_video_only_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_video_write) |-> wr_reg)
        else $error("video flag raised on a read");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == mmbd_pkg::ST_CLEAR || state_reg == mmbd_pkg::ST_MOD))
        else $error("store written outside clear or modify");

endmodule

`default_nettype wire
